@@ design/pif_pkg.sv @@
package pif_pkg;

  localparam int unsigned NDIG_W = 7;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOW_A   = 8'h61;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_H = 8'h68;
  localparam logic [7:0] CH_L = 8'h6C;
  localparam logic [7:0] CH_J = 8'h6A;
  localparam logic [7:0] CH_Z = 8'h7A;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_D = 8'h64;
  localparam logic [7:0] CH_I = 8'h69;
  localparam logic [7:0] CH_U = 8'h75;
  localparam logic [7:0] CH_O = 8'h6F;
  localparam logic [7:0] CH_P = 8'h70;
  localparam logic [7:0] CH_X = 8'h78;
  localparam logic [7:0] CH_UX = 8'h58;
  localparam logic [7:0] CH_C = 8'h63;
  localparam logic [7:0] CH_N = 8'h6E;

  localparam logic [30:0] COUNT_MAX = 31'h7FFF_FFFF;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_FLAGS  = 3'd1,
    MODE_WIDTH  = 3'd2,
    MODE_LEN    = 3'd3
  } parse_mode_e;

  typedef enum logic [2:0] {
    LEN_HH = 3'd0, LEN_H = 3'd1, LEN_NONE = 3'd2, LEN_L = 3'd3,
    LEN_LL = 3'd4, LEN_J = 3'd5, LEN_Z = 3'd6, LEN_T = 3'd7
  } len_mod_e;

  typedef enum logic [1:0] {
    RDX_DEC, RDX_OCT, RDX_HEX
  } radix_e;

  typedef enum logic [1:0] {
    DG_IDLE, DG_DABBLE, DG_NORM, DG_READY
  } dig_phase_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PARSE, ST_ONE, ST_WAIT, ST_PADS, ST_SIGN, ST_PADZ, ST_DIGS, ST_FIN
  } fmt_state_e;

  typedef struct packed {
    logic [7:0]  fmt_char;
    logic [63:0] arg_value;
    logic        format_last;
  } in_beat_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  out_char;
    logic [30:0] count;
    logic        last;
  } out_beat_t;

  typedef struct packed {
    logic        start;
    radix_e      radix;
    logic [63:0] mag;
    logic        shift;
  } dig_cmd_t;

  typedef struct packed {
    logic              done;
    logic [NDIG_W-1:0] ndig;
    logic [3:0]        top;
  } dig_stat_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CH_UP_A : CH_LOW_A;
    if (d < 4'd10) return CH_ZERO + {4'd0, d};
    return base + {4'd0, d} - 8'd10;
  endfunction

endpackage

@@ design/pif_in_if.sv @@
interface pif_in_if import pif_pkg::*; ();
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/pif_out_if.sv @@
interface pif_out_if import pif_pkg::*; ();
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/pif_digits.sv @@
// Digit engine: loads a magnitude, converts it to digits (shift-add-3 for
// decimal, regrouping for octal and hex), strips leading zeros one digit per
// cycle and then hands out digits from the most significant end.
module pif_digits import pif_pkg::*; #(
  parameter int unsigned DIGIT_SLOTS = 22
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  dig_cmd_t  cmd_i,
  output dig_stat_t stat_o
);

  localparam int unsigned DW = DIGIT_SLOTS * 4;

  dig_phase_e        phase_q, phase_d;
  logic [DW-1:0]     digs_q, digs_d;
  logic [63:0]       mag_q, mag_d;
  logic [5:0]        cnt_q, cnt_d;
  logic [NDIG_W-1:0] ndig_q, ndig_d;

  logic [DW-1:0] ext, oct_v, hex_v, adj;

  always_comb begin
    ext = DW'(cmd_i.mag);
    for (int i = 0; i < DIGIT_SLOTS; i++) begin
      oct_v[4*i +: 4] = {1'b0, ext[3*i +: 3]};
      hex_v[4*i +: 4] = ext[4*i +: 4];
      adj[4*i +: 4] = (digs_q[4*i +: 4] >= 4'd5) ? digs_q[4*i +: 4] + 4'd3
                                                 : digs_q[4*i +: 4];
    end
  end

  always_comb begin
    phase_d = phase_q;
    digs_d  = digs_q;
    mag_d   = mag_q;
    cnt_d   = cnt_q;
    ndig_d  = ndig_q;
    unique case (phase_q)
      DG_IDLE, DG_READY: begin
        if (phase_q == DG_READY && cmd_i.shift) begin
          digs_d = {digs_q[DW-5:0], 4'd0};
          ndig_d = ndig_q - 1'b1;
        end
      end
      DG_DABBLE: begin
        digs_d = {adj[DW-2:0], mag_q[63]};
        mag_d  = {mag_q[62:0], 1'b0};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == 6'd63) phase_d = DG_NORM;
      end
      DG_NORM: begin
        if (ndig_q > NDIG_W'(1) && digs_q[DW-1 -: 4] == 4'd0) begin
          digs_d = {digs_q[DW-5:0], 4'd0};
          ndig_d = ndig_q - 1'b1;
        end else begin
          phase_d = DG_READY;
        end
      end
      default: phase_d = DG_IDLE;
    endcase
    if (cmd_i.start) begin
      ndig_d = NDIG_W'(DIGIT_SLOTS);
      cnt_d  = '0;
      mag_d  = cmd_i.mag;
      unique case (cmd_i.radix)
        RDX_OCT: begin
          digs_d  = oct_v;
          phase_d = DG_NORM;
        end
        RDX_HEX: begin
          digs_d  = hex_v;
          phase_d = DG_NORM;
        end
        default: begin
          digs_d  = '0;
          phase_d = DG_DABBLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= DG_IDLE;
      cnt_q   <= '0;
      ndig_q  <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      ndig_q  <= ndig_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digs_q <= digs_d;
    mag_q  <= mag_d;
  end

  assign stat_o.done = (phase_q == DG_READY);
  assign stat_o.ndig = ndig_q;
  assign stat_o.top  = digs_q[DW-1 -: 4];

endmodule

@@ design/printf_integer_formatter_top.sv @@
// Flow: a format byte is taken, held and parsed; a plain character or count
// report then goes from ST_ONE to the output register. A decimal conversion
// runs the shift-add-3 converter, octal and hex skip it; then leading zeros
// are dropped, then digits go out one beat per cycle while out_o is ready.
// Only one format byte is taken at a time; a new byte waits until the last is done.
// Reset: rst_ni is asynchronous, active low, and returns the parser to text.
module printf_integer_formatter_top import pif_pkg::*; #(
  parameter int unsigned MAX_WIDTH   = 63,
  parameter int unsigned DIGIT_SLOTS = 22
) (
  input logic      clk_i,
  input logic      rst_ni,
  pif_in_if.sink   in_i,
  pif_out_if.source out_o
);

  // Parser state that persists between format bytes.
  fmt_state_e  state_q, state_d;
  parse_mode_e mode_q, mode_d;
  len_mod_e    lm_q, lm_d;
  logic        plus_q, plus_d, zero_q, zero_d;
  logic [5:0]  width_q, width_d;
  logic [30:0] count_q, count_d;

  // The byte being worked on.
  logic [7:0]  char_q, char_d;
  logic [63:0] arg_q, arg_d;
  logic        fin_q, fin_d;

  // A single result held for the emit state, and the open conversion.
  logic        one_kind_q, one_kind_d;
  logic [7:0]  one_char_q, one_char_d;
  logic        czero_q, czero_d, cupper_q, cupper_d;
  logic [5:0]  cwidth_q, cwidth_d;
  logic        sgn_q, sgn_d;
  logic [7:0]  sgnch_q, sgnch_d;
  logic [NDIG_W-1:0] pad_q, pad_d;

  // Output register.
  logic      ovalid_q, ovalid_d;
  out_beat_t obeat_q, obeat_d;
  logic      out_load;
  out_beat_t onext;

  dig_cmd_t  dcmd;
  dig_stat_t dstat;

  pif_digits #(.DIGIT_SLOTS(DIGIT_SLOTS)) u_digits (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (dcmd),
    .stat_o(dstat)
  );

  logic emit_ok;
  assign emit_ok = !ovalid_q || out_o.ready;

  // Parse decode on the held byte. A byte can fall through flags, width and
  // length modifier into the conversion letter within the same step.
  logic        is_digit, go_width, go_len, is_lenc, go_spec, wide, is_signed, neg;
  logic [9:0]  wnum;
  logic [63:0] mag;
  logic [NDIG_W-1:0] total;

  always_comb begin
    is_digit = (char_q >= CH_ZERO) && (char_q <= CH_NINE);
    go_width = (mode_q == MODE_WIDTH) ||
               ((mode_q == MODE_FLAGS) && char_q != CH_PLUS && char_q != CH_ZERO);
    go_len   = (mode_q == MODE_LEN) || (go_width && char_q != CH_STAR && !is_digit);
    is_lenc  = char_q == CH_H || char_q == CH_L || char_q == CH_J ||
               char_q == CH_Z || char_q == CH_T;
    go_spec  = go_len && !is_lenc;
    wnum     = 10'(width_q) * 10'd10 + 10'(char_q - CH_ZERO);
    wide     = (lm_q >= LEN_L);
    is_signed = (char_q == CH_D) || (char_q == CH_I);
    neg      = is_signed && (wide ? arg_q[63] : arg_q[31]);
    if (!neg) mag = wide ? arg_q : {32'd0, arg_q[31:0]};
    else      mag = wide ? (~arg_q + 64'd1) : {32'd0, ~arg_q[31:0] + 32'd1};
    total    = dstat.ndig + NDIG_W'(sgn_q);
  end

  always_comb begin
    state_d = state_q; mode_d = mode_q; lm_d = lm_q;
    plus_d = plus_q; zero_d = zero_q; width_d = width_q; count_d = count_q;
    char_d = char_q; arg_d = arg_q; fin_d = fin_q;
    one_kind_d = one_kind_q; one_char_d = one_char_q;
    czero_d = czero_q; cupper_d = cupper_q; cwidth_d = cwidth_q;
    sgn_d = sgn_q; sgnch_d = sgnch_q; pad_d = pad_q;
    ovalid_d = ovalid_q; obeat_d = obeat_q;
    out_load = 1'b0;
    onext    = '0;
    dcmd     = '0;
    in_i.ready = (state_q == ST_IDLE);

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          char_d  = in_i.data.fmt_char;
          arg_d   = in_i.data.arg_value;
          fin_d   = in_i.data.format_last;
          state_d = ST_PARSE;
        end
      end
      ST_PARSE: begin
        state_d = fin_q ? ST_FIN : ST_IDLE;
        if (mode_q == MODE_FLAGS && char_q == CH_PLUS) begin
          plus_d = 1'b1;
        end else if (mode_q == MODE_FLAGS && char_q == CH_ZERO) begin
          zero_d = 1'b1;
        end else if (go_width && char_q == CH_STAR) begin
          if (arg_q[31]) width_d = '0;
          else if (arg_q[31:0] > 32'(MAX_WIDTH)) width_d = 6'(MAX_WIDTH);
          else width_d = arg_q[5:0];
          mode_d = MODE_LEN;
        end else if (go_width && is_digit) begin
          width_d = (wnum > 10'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : wnum[5:0];
          mode_d  = MODE_WIDTH;
        end else if (go_len && is_lenc) begin
          mode_d = MODE_LEN;
          priority case (char_q)
            CH_H:    lm_d = (lm_q == LEN_H) ? LEN_HH : LEN_H;
            CH_L:    lm_d = (lm_q == LEN_L) ? LEN_LL : LEN_L;
            CH_J:    lm_d = LEN_J;
            CH_Z:    lm_d = LEN_Z;
            default: lm_d = LEN_T;
          endcase
        end else if (go_spec) begin
          mode_d = MODE_NORMAL; lm_d = LEN_NONE;
          plus_d = 1'b0; zero_d = 1'b0; width_d = '0;
          czero_d  = zero_q;
          cwidth_d = width_q;
          cupper_d = (char_q == CH_UX);
          sgn_d    = neg || (is_signed && plus_q);
          sgnch_d  = neg ? CH_MINUS : CH_PLUS;
          dcmd.mag = mag;
          priority case (char_q)
            CH_D, CH_I, CH_U: begin
              dcmd.start = 1'b1; dcmd.radix = RDX_DEC; state_d = ST_WAIT;
            end
            CH_O: begin
              dcmd.start = 1'b1; dcmd.radix = RDX_OCT; state_d = ST_WAIT;
            end
            CH_P, CH_X, CH_UX: begin
              dcmd.start = 1'b1; dcmd.radix = RDX_HEX; state_d = ST_WAIT;
            end
            CH_C: begin
              one_kind_d = 1'b0; one_char_d = arg_q[7:0]; state_d = ST_ONE;
            end
            CH_PERCENT: begin
              one_kind_d = 1'b0; one_char_d = CH_PERCENT; state_d = ST_ONE;
            end
            CH_N: begin
              one_kind_d = 1'b1; one_char_d = '0; state_d = ST_ONE;
            end
            default: ;
          endcase
        end else if (char_q == CH_PERCENT) begin
          mode_d = MODE_FLAGS;
        end else begin
          one_kind_d = 1'b0; one_char_d = char_q; state_d = ST_ONE;
        end
      end
      ST_ONE: begin
        if (emit_ok) begin
          out_load       = 1'b1;
          onext.kind     = one_kind_q;
          onext.out_char = one_char_q;
          onext.count    = one_kind_q ? count_q : '0;
          onext.last     = !fin_q;
          state_d        = fin_q ? ST_FIN : ST_IDLE;
        end
      end
      ST_WAIT: begin
        if (dstat.done) begin
          pad_d   = (NDIG_W'(cwidth_q) > total) ? NDIG_W'(cwidth_q) - total : '0;
          state_d = ST_PADS;
        end
      end
      ST_PADS: begin
        if (!czero_q && pad_q != '0) begin
          if (emit_ok) begin
            out_load = 1'b1; onext.out_char = CH_SPACE; pad_d = pad_q - 1'b1;
          end
        end else begin
          state_d = ST_SIGN;
        end
      end
      ST_SIGN: begin
        if (!sgn_q) begin
          state_d = ST_PADZ;
        end else if (emit_ok) begin
          out_load = 1'b1; onext.out_char = sgnch_q; state_d = ST_PADZ;
        end
      end
      ST_PADZ: begin
        if (czero_q && pad_q != '0) begin
          if (emit_ok) begin
            out_load = 1'b1; onext.out_char = CH_ZERO; pad_d = pad_q - 1'b1;
          end
        end else begin
          state_d = ST_DIGS;
        end
      end
      ST_DIGS: begin
        if (emit_ok) begin
          out_load       = 1'b1;
          dcmd.shift     = 1'b1;
          onext.out_char = digit_char(dstat.top, cupper_q);
          onext.last     = (dstat.ndig == NDIG_W'(1)) && !fin_q;
          if (dstat.ndig == NDIG_W'(1)) state_d = fin_q ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: begin
        if (emit_ok) begin
          out_load    = 1'b1;
          onext.kind  = 1'b1;
          onext.count = count_q;
          onext.last  = 1'b1;
          mode_d = MODE_NORMAL; lm_d = LEN_NONE;
          plus_d = 1'b0; zero_d = 1'b0; width_d = '0;
          count_d = '0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // Every character beat counts toward the saturating total.
    if (out_load && !onext.kind && count_q != COUNT_MAX) count_d = count_q + 1'b1;

    if (out_o.ready) ovalid_d = 1'b0;
    if (out_load) begin
      ovalid_d = 1'b1;
      obeat_d  = onext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      mode_q   <= MODE_NORMAL;
      lm_q     <= LEN_NONE;
      plus_q   <= 1'b0;
      zero_q   <= 1'b0;
      width_q  <= '0;
      count_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      lm_q     <= lm_d;
      plus_q   <= plus_d;
      zero_q   <= zero_d;
      width_q  <= width_d;
      count_q  <= count_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q     <= char_d;
    arg_q      <= arg_d;
    fin_q      <= fin_d;
    one_kind_q <= one_kind_d;
    one_char_q <= one_char_d;
    czero_q    <= czero_d;
    cupper_q   <= cupper_d;
    cwidth_q   <= cwidth_d;
    sgn_q      <= sgn_d;
    sgnch_q    <= sgnch_d;
    pad_q      <= pad_d;
    obeat_q    <= obeat_d;
  end

  assign out_o.valid = ovalid_q;
  assign out_o.data  = obeat_q;

endmodule

@@ design/pif_checker.sv @@
module pif_checker import pif_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_beat_t out_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i) else $error("output beat dropped");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i)) else $error("stalled beat changed");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i) else $error("second byte taken while busy");

  a_char_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.kind |-> out_data_i.count == '0)
    else $error("character beat carries a count");

  a_report_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.kind |-> out_data_i.out_char == '0)
    else $error("count report carries a character");

endmodule

bind printf_integer_formatter_top pif_checker u_pif_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_data_i (out_o.data)
);
